FILE: hdl/replan_blockage_classifier_core_macros.svh
// Assertion helpers for the blockage classifier checker.
`ifndef REPLAN_BLOCKAGE_CLASSIFIER_CORE_MACROS_SVH
`define REPLAN_BLOCKAGE_CLASSIFIER_CORE_MACROS_SVH

// Checked only out of reset.
`define RBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rbc check failed");

// Checked at every edge, reset included.
`define RBC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rbc check failed");

`endif

FILE: hdl/rbc_pkg.sv
package rbc_pkg;

  localparam int RBC_MAX_POINTS  = 1024;
  localparam int RBC_COORD_BITS  = 32;
  localparam int LEN_W           = 44;
  localparam int GOAL_W          = 32;
  localparam int CFG_IDX_W       = 8;
  localparam int MIN_PLAN_POINTS = 2;

  localparam logic [LEN_W-1:0] LEN_MAX      = '1;
  localparam logic [LEN_W-1:0] THRESH_RESET = LEN_W'(65536);

  typedef enum logic [1:0] {
    V_NEW     = 2'd0,
    V_PARTIAL = 2'd1,
    V_FULL    = 2'd2,
    V_FAILED  = 2'd3
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESH = 8'd0,
    REG_REPLAN = 8'd1
  } cfg_reg_t;

  // per-item classification made at the front
  typedef struct packed {
    logic first;
    logic drop;
    logic last;
    logic ovf;
  } item_ctl_t;

  typedef enum logic [1:0] {
    M_NEAR,
    M_NEW,
    M_OLD
  } dist_mode_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DISPATCH,
    B_NEW_CHK,
    B_RD,
    B_DIFF,
    B_MUL,
    B_SUM,
    B_SQRT,
    B_WRITE,
    B_JUDGE,
    B_OLD_LD,
    B_OLD_LD2,
    B_DECIDE
  } back_state_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } sqrt_state_t;

endpackage

FILE: hdl/rbc_sqrt.sv
module rbc_sqrt import rbc_pkg::*; #(
  parameter int IW = 2 * RBC_COORD_BITS + 2,
  localparam int OW = IW / 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [IW-1:0] radicand,
  output logic          done,
  output logic [OW-1:0] root
);

  localparam int CNTW = $clog2(OW + 1);

  sqrt_state_t state_r, state_nxt;
  logic [IW-1:0]   rad_r;
  logic [OW:0]     rem_r;
  logic [OW-1:0]   root_r;
  logic [CNTW-1:0] cnt_r;
  logic            done_r;

  logic [OW+2:0] rem_sh, trial, rem_sub;
  logic          take;
  logic          last_step;

  // one result bit per cycle, restoring method
  always_comb begin
    rem_sh    = {rem_r, rad_r[IW-1:IW-2]};
    trial     = {1'b0, root_r, 2'b01};
    take      = rem_sh >= trial;
    rem_sub   = rem_sh - trial;
    last_step = cnt_r == CNTW'(OW - 1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_RUN;
      S_RUN:  if (last_step) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == S_RUN) && last_step;
      if (state_r == S_IDLE && start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end else if (state_r == S_RUN) begin
        rad_r  <= {rad_r[IW-3:0], 2'b00};
        rem_r  <= take ? rem_sub[OW:0] : rem_sh[OW:0];
        root_r <= {root_r[OW-2:0], take};
        cnt_r  <= cnt_r + CNTW'(1);
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: hdl/rbc_front.sv
module rbc_front import rbc_pkg::*; #(
  parameter int MAX_POINTS = RBC_MAX_POINTS,
  parameter int COORD_BITS = RBC_COORD_BITS,
  localparam int AW = $clog2(MAX_POINTS),
  localparam int CW = AW + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] in_point_x,
  input  logic [COORD_BITS-1:0] in_point_y,
  input  logic                  in_last_point,
  input  logic [GOAL_W-1:0]     in_goal_key,
  output logic                  q_valid,
  input  logic                  q_pop,
  output item_ctl_t             q_ctl,
  output logic [AW-1:0]         q_idx,
  output logic [COORD_BITS-1:0] q_x,
  output logic [COORD_BITS-1:0] q_y,
  output logic [GOAL_W-1:0]     q_goal
);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;

  item_ctl_t             ctl_q  [2];
  logic [AW-1:0]         idx_q  [2];
  logic [COORD_BITS-1:0] x_q    [2];
  logic [COORD_BITS-1:0] y_q    [2];
  logic [GOAL_W-1:0]     goal_q [2];

  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] level_r;
  logic       push;
  item_ctl_t  ctl_new;

  assign busy = level_r == 2'd2;
  assign push = start && !busy;

  always_comb begin
    ctl_new.first = (cnt_r == '0) && !ovf_r;
    ctl_new.drop  = cnt_r >= CW'(MAX_POINTS);
    ctl_new.last  = in_last_point;
    ctl_new.ovf   = ovf_r || ctl_new.drop;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (push) begin
      if (in_last_point) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        ovf_nxt = ctl_new.ovf;
        if (!ctl_new.drop) cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      level_r <= level_r + {1'b0, push} - {1'b0, q_pop};
      if (push)  wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_q[wr_ptr_r]  <= ctl_new;
      idx_q[wr_ptr_r]  <= cnt_r[AW-1:0];
      x_q[wr_ptr_r]    <= in_point_x;
      y_q[wr_ptr_r]    <= in_point_y;
      goal_q[wr_ptr_r] <= in_goal_key;
    end
  end

  assign q_valid = level_r != 2'd0;
  assign q_ctl   = ctl_q[rd_ptr_r];
  assign q_idx   = idx_q[rd_ptr_r];
  assign q_x     = x_q[rd_ptr_r];
  assign q_y     = y_q[rd_ptr_r];
  assign q_goal  = goal_q[rd_ptr_r];

endmodule

FILE: hdl/rbc_back.sv
module rbc_back import rbc_pkg::*; #(
  parameter int MAX_POINTS = RBC_MAX_POINTS,
  parameter int COORD_BITS = RBC_COORD_BITS,
  localparam int AW = $clog2(MAX_POINTS),
  localparam int CW = AW + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  item_ctl_t             q_ctl,
  input  logic [AW-1:0]         q_idx,
  input  logic [COORD_BITS-1:0] q_x,
  input  logic [COORD_BITS-1:0] q_y,
  input  logic [GOAL_W-1:0]     q_goal,
  input  logic [LEN_W-1:0]      partial_threshold,
  input  logic                  allow_replan,
  output logic                  out_valid,
  output logic [1:0]            out_verdict,
  output logic [LEN_W-1:0]      out_length_diff
);

  localparam int C     = COORD_BITS;
  localparam int BW    = AW + 1;
  localparam int DEPTH = 2 ** BW;
  localparam int SQW   = C + 1;
  localparam int RADW  = 2 * C + 2;
  localparam int SUMW  = ((LEN_W > SQW) ? LEN_W : SQW) + 1;

  function automatic logic [C-1:0] absd(input logic [C-1:0] a, input logic [C-1:0] b);
    logic signed [C:0] d;
    d = $signed({a[C-1], a}) - $signed({b[C-1], b});
    return d[C] ? C'(-d) : d[C-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [SQW-1:0] b);
    logic [SUMW-1:0] s;
    s = SUMW'(a) + SUMW'(b);
    return (s > SUMW'(LEN_MAX)) ? LEN_MAX : s[LEN_W-1:0];
  endfunction

  // both plans share one memory; the bank bit picks the stored half
  logic [C-1:0] mem_x [DEPTH];
  logic [C-1:0] mem_y [DEPTH];

  back_state_t state_r, state_nxt;
  dist_mode_t  mode_r;
  item_ctl_t   cur_ctl_r;
  logic [AW-1:0]     cur_idx_r;
  logic [C-1:0]      cur_x_r, cur_y_r;
  logic [GOAL_W-1:0] cur_goal_r;
  logic [CW-1:0]     i_r;
  logic [C-1:0]      opb_x_r, opb_y_r, rdx_r, rdy_r, dx_r, dy_r;
  logic [2*C-1:0]    sqx_r, sqy_r;
  logic [2*C:0]      best_r;
  logic [AW-1:0]     nearest_r;
  logic              have_r, sbank_r;
  logic [CW-1:0]     scount_r;
  logic [GOAL_W-1:0] sgoal_r;
  logic [LEN_W-1:0]  newlen_r, oldlen_r;
  logic              out_valid_r;
  verdict_t          out_verdict_r;
  logic [LEN_W-1:0]  out_diff_r;

  logic              rd_en, wr_en, sq_start, sq_done;
  logic [BW-1:0]     rd_addr, wr_addr;
  logic [SQW-1:0]    sq_root;
  logic [2*C:0]      dsum;
  logic [CW-1:0]     i_plus, i_plus2, cnt_in, near_ext;
  logic [AW-1:0]     prev_idx;
  logic              goal_changed, fail_c;
  logic [LEN_W-1:0]  ldiff;

  always_comb begin
    dsum     = {1'b0, sqx_r} + {1'b0, sqy_r};
    i_plus   = i_r + CW'(1);
    i_plus2  = i_r + CW'(2);
    cnt_in   = {1'b0, cur_idx_r} + CW'(1);
    near_ext = {1'b0, nearest_r};
    prev_idx = cur_idx_r - AW'(1);
    goal_changed = !have_r || (cur_goal_r != sgoal_r);
    fail_c   = (near_ext >= scount_r) || (scount_r - near_ext < CW'(MIN_PLAN_POINTS)) ||
               (cnt_in < CW'(MIN_PLAN_POINTS));
    ldiff    = (oldlen_r > newlen_r) ? oldlen_r - newlen_r : newlen_r - oldlen_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:     if (q_valid) state_nxt = B_DISPATCH;
      B_DISPATCH: state_nxt = (cur_ctl_r.first && have_r) ? B_RD : B_NEW_CHK;
      B_NEW_CHK: begin
        if (cur_ctl_r.drop)          state_nxt = B_JUDGE;
        else if (cur_idx_r != '0)    state_nxt = B_RD;
        else                         state_nxt = B_WRITE;
      end
      B_RD:   state_nxt = B_DIFF;
      B_DIFF: state_nxt = B_MUL;
      B_MUL:  state_nxt = B_SUM;
      B_SUM: begin
        if (mode_r != M_NEAR)        state_nxt = B_SQRT;
        else if (i_plus < scount_r)  state_nxt = B_RD;
        else                         state_nxt = B_NEW_CHK;
      end
      B_SQRT: begin
        if (sq_done) begin
          if (mode_r == M_NEW)            state_nxt = B_WRITE;
          else if (i_plus2 < scount_r)    state_nxt = B_RD;
          else                            state_nxt = B_DECIDE;
        end
      end
      B_WRITE: state_nxt = B_JUDGE;
      B_JUDGE: begin
        if (!cur_ctl_r.last || cur_ctl_r.ovf || goal_changed || fail_c) state_nxt = B_IDLE;
        else state_nxt = B_OLD_LD;
      end
      B_OLD_LD:  state_nxt = B_OLD_LD2;
      B_OLD_LD2: state_nxt = B_RD;
      B_DECIDE:  state_nxt = B_IDLE;
      default:   state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state_r == B_IDLE) && q_valid;
    rd_en    = 1'b0;
    rd_addr  = {sbank_r, i_r[AW-1:0]};
    wr_en    = state_r == B_WRITE;
    wr_addr  = {!sbank_r, cur_idx_r};
    sq_start = (state_r == B_SUM) && (mode_r != M_NEAR);
    unique case (state_r)
      B_RD: begin
        rd_en = 1'b1;
        case (mode_r)
          M_NEW:   rd_addr = {!sbank_r, prev_idx};
          M_OLD:   rd_addr = {sbank_r, i_plus[AW-1:0]};
          default: rd_addr = {sbank_r, i_r[AW-1:0]};
        endcase
      end
      B_OLD_LD: rd_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdx_r <= mem_x[rd_addr];
      rdy_r <= mem_y[rd_addr];
    end
    if (wr_en) begin
      mem_x[wr_addr] <= cur_x_r;
      mem_y[wr_addr] <= cur_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      have_r      <= 1'b0;
      sbank_r     <= 1'b0;
      scount_r    <= '0;
      sgoal_r     <= '0;
      nearest_r   <= '0;
      newlen_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            cur_ctl_r  <= q_ctl;
            cur_idx_r  <= q_idx;
            cur_x_r    <= q_x;
            cur_y_r    <= q_y;
            cur_goal_r <= q_goal;
          end
        end
        B_DISPATCH: begin
          if (cur_ctl_r.first) nearest_r <= '0;
          mode_r  <= M_NEAR;
          i_r     <= '0;
          opb_x_r <= cur_x_r;
          opb_y_r <= cur_y_r;
        end
        B_NEW_CHK: begin
          mode_r  <= M_NEW;
          opb_x_r <= cur_x_r;
          opb_y_r <= cur_y_r;
        end
        B_DIFF: begin
          dx_r <= absd(rdx_r, opb_x_r);
          dy_r <= absd(rdy_r, opb_y_r);
        end
        B_MUL: begin
          sqx_r <= dx_r * dx_r;
          sqy_r <= dy_r * dy_r;
        end
        B_SUM: begin
          if (mode_r == M_NEAR) begin
            // strict less: first minimum wins
            if (i_r == '0 || dsum < best_r) begin
              best_r    <= dsum;
              nearest_r <= i_r[AW-1:0];
            end
            i_r <= i_plus;
          end
        end
        B_SQRT: begin
          if (sq_done) begin
            if (mode_r == M_NEW) begin
              newlen_r <= sat_add(newlen_r, sq_root);
            end else begin
              oldlen_r <= sat_add(oldlen_r, sq_root);
              opb_x_r  <= rdx_r;
              opb_y_r  <= rdy_r;
              i_r      <= i_plus;
            end
          end
        end
        B_JUDGE: begin
          if (cur_ctl_r.last) begin
            if (cur_ctl_r.ovf || (!goal_changed && fail_c)) begin
              out_valid_r   <= 1'b1;
              out_verdict_r <= V_FAILED;
              out_diff_r    <= '0;
              newlen_r      <= '0;
            end else if (goal_changed) begin
              sbank_r       <= !sbank_r;
              scount_r      <= cnt_in;
              sgoal_r       <= cur_goal_r;
              have_r        <= 1'b1;
              out_valid_r   <= 1'b1;
              out_verdict_r <= V_NEW;
              out_diff_r    <= '0;
              newlen_r      <= '0;
            end else begin
              oldlen_r <= '0;
              i_r      <= near_ext;
            end
          end
        end
        B_OLD_LD2: begin
          mode_r  <= M_OLD;
          opb_x_r <= rdx_r;
          opb_y_r <= rdy_r;
        end
        B_DECIDE: begin
          out_valid_r <= 1'b1;
          out_diff_r  <= ldiff;
          newlen_r    <= '0;
          if (ldiff < partial_threshold) begin
            out_verdict_r <= V_PARTIAL;
            if (allow_replan) begin
              sbank_r  <= !sbank_r;
              scount_r <= cnt_in;
            end
          end else begin
            out_verdict_r <= V_FULL;
          end
        end
        default: ;
      endcase
    end
  end

  rbc_sqrt #(.IW(RADW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({1'b0, dsum}),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign out_valid       = out_valid_r;
  assign out_verdict     = out_verdict_r;
  assign out_length_diff = out_diff_r;

endmodule

FILE: hdl/replan_blockage_classifier_core.sv
// A mid-plan point leaving the queue adds its segment length to the new plan, mostly one
// serial square root; a first point first scans every stored waypoint for the nearest one.
// A last point then walks the stored segments from the nearest one, a square root for each.
// Throughput: one point at a time in the back end; a two-entry queue takes points early.
// Result is a one-cycle out_valid strobe. Synchronous active-low reset clears control
// and settings; the plan memory is not cleared and needs no sweep.
module replan_blockage_classifier_core import rbc_pkg::*; #(
  parameter int MAX_POINTS = RBC_MAX_POINTS,
  parameter int COORD_BITS = RBC_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] in_point_x,
  input  logic [COORD_BITS-1:0] in_point_y,
  input  logic                  in_last_point,
  input  logic [GOAL_W-1:0]     in_goal_key,
  output logic                  out_valid,
  output logic [1:0]            out_verdict,
  output logic [LEN_W-1:0]      out_length_diff,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LEN_W-1:0]      cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);

  logic [LEN_W-1:0] thresh_r;
  logic             replan_r;

  logic                  q_valid, q_pop;
  item_ctl_t             q_ctl;
  logic [AW-1:0]         q_idx;
  logic [COORD_BITS-1:0] q_x, q_y;
  logic [GOAL_W-1:0]     q_goal;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      replan_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      // writes to unknown indexes are dropped
      if (cfg_index == REG_THRESH) thresh_r <= cfg_data;
      if (cfg_index == REG_REPLAN) replan_r <= cfg_data[0];
    end
  end

  rbc_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_last_point (in_last_point),
    .in_goal_key   (in_goal_key),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_ctl         (q_ctl),
    .q_idx         (q_idx),
    .q_x           (q_x),
    .q_y           (q_y),
    .q_goal        (q_goal)
  );

  rbc_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_ctl             (q_ctl),
    .q_idx             (q_idx),
    .q_x               (q_x),
    .q_y               (q_y),
    .q_goal            (q_goal),
    .partial_threshold (thresh_r),
    .allow_replan      (replan_r),
    .out_valid         (out_valid),
    .out_verdict       (out_verdict),
    .out_length_diff   (out_length_diff)
  );

endmodule

FILE: hdl/rbc_checker.sv
`include "replan_blockage_classifier_core_macros.svh"

module rbc_checker import rbc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic [1:0]       out_verdict,
  input logic [LEN_W-1:0] out_length_diff
);

  `RBC_ASSERT(a_strobe_single, out_valid |=> !out_valid)
  `RBC_ASSERT(a_new_goal_no_diff, out_valid && out_verdict == V_NEW |-> out_length_diff == '0)
  `RBC_ASSERT(a_failed_no_diff, out_valid && out_verdict == V_FAILED |-> out_length_diff == '0)
  `RBC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid)

endmodule

bind replan_blockage_classifier_core rbc_checker u_rbc_checker (.*);
